// File: rtl/core/sklat_pkg.sv
package sklat_pkg;

  localparam int unsigned REQ_W = 9;
  localparam int unsigned OUT_W = 8;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_NEW_SHEET = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NO_SHEETS = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_UP,
    S_DOWN,
    S_EVAL,
    S_NEW,
    S_CLEAR,
    S_WRITE,
    S_RESP
  } fsm_state_e;

  typedef struct packed {
    status_e           status;
    logic [OUT_W-1:0]  sheet_number;
    logic [OUT_W-1:0]  pos_s;
    logic [OUT_W-1:0]  pos_t;
  } res_t;

endpackage

// File: rtl/core/sklat_colmem.sv
module sklat_colmem
  import sklat_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned DW    = 9
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [DW-1:0]            wdata_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sklat_pfxmem.sv
module sklat_pfxmem
  import sklat_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned DW    = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [DW-1:0]            rdata_a_o,
  output logic [DW-1:0]            rdata_b_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_a_q;
  logic [DW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/core/sklat_engine.sv
module sklat_engine
  import sklat_pkg::*;
#(
  parameter int unsigned SHEET_WIDTH  = 256,
  parameter int unsigned SHEET_HEIGHT = 256,
  parameter int unsigned MAX_SHEETS   = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_width_i,
  input  logic [REQ_W-1:0] req_height_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int unsigned IW   = $clog2(SHEET_WIDTH);
  localparam int unsigned HW   = $clog2(SHEET_HEIGHT + 1);
  localparam int unsigned SW   = $clog2(MAX_SHEETS + 1);
  localparam int unsigned XW   = ((IW > REQ_W) ? IW : REQ_W) + 1;
  localparam int unsigned SUMW = ((HW > REQ_W) ? HW : REQ_W) + 1;
  localparam logic [IW-1:0] LAST = IW'(SHEET_WIDTH - 1);

  fsm_state_e state_q, state_d;
  logic             iss_q, iss_d;
  logic             p_vld_q, p_vld_d;
  logic [IW-1:0]    p_idx_q, p_idx_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [SW-1:0]    sheets_q, sheets_d;
  logic [REQ_W-1:0] w_q, w_d;
  logic [REQ_W-1:0] h_q, h_d;
  logic [REQ_W-1:0] blk_q, blk_d;
  logic [REQ_W-1:0] rem_q, rem_d;
  logic [HW-1:0]    prefix_q, prefix_d;
  logic [HW-1:0]    suf_q, suf_d;
  logic [HW-1:0]    best_q, best_d;
  logic [HW-1:0]    wval_q, wval_d;
  logic [IW-1:0]    pos_q, pos_d;
  logic             found_q, found_d;
  res_t             res_q, res_d;

  logic          col_we;
  logic [HW-1:0] col_wdata;
  logic [HW-1:0] col_rdata;
  logic          pfx_we;
  logic [HW:0]   pfx_wdata;
  logic [IW-1:0] pfx_raddr_b;
  logic [HW:0]   pfx_rdata_a;
  logic [HW:0]   pfx_rdata_b;

  logic [HW-1:0] pre_v;
  logic          blk_end;
  logic [HW-1:0] suf_v;
  logic [HW-1:0] pfx_v;
  logic [HW-1:0] win_v;
  logic          win_in;
  logic          fits;
  logic          bad_req;

  sklat_colmem #(
    .DEPTH (SHEET_WIDTH),
    .DW    (HW)
  ) u_colmem (
    .clk_i   (clk_i),
    .addr_i  (cnt_q),
    .we_i    (col_we),
    .wdata_i (col_wdata),
    .rdata_o (col_rdata)
  );

  sklat_pfxmem #(
    .DEPTH (SHEET_WIDTH),
    .DW    (HW + 1)
  ) u_pfxmem (
    .clk_i     (clk_i),
    .we_i      (pfx_we),
    .waddr_i   (p_idx_q),
    .wdata_i   (pfx_wdata),
    .raddr_a_i (cnt_q),
    .raddr_b_i (pfx_raddr_b),
    .rdata_a_o (pfx_rdata_a),
    .rdata_b_o (pfx_rdata_b)
  );

  // prefix pass, blocks of w columns from the left
  assign pre_v   = (blk_q == '0 || col_rdata > prefix_q) ? col_rdata : prefix_q;
  assign blk_end = (blk_q == REQ_W'(w_q - REQ_W'(1))) || (p_idx_q == LAST);
  assign pfx_wdata = {blk_end, pre_v};
  assign pfx_we    = p_vld_q && (state_q == S_UP);

  // suffix pass, window max from both halves
  assign pfx_raddr_b = IW'(XW'(cnt_q) + XW'(w_q) - XW'(1));
  assign suf_v  = (pfx_rdata_a[HW] || col_rdata > suf_q) ? col_rdata : suf_q;
  assign pfx_v  = pfx_rdata_b[HW-1:0];
  assign win_v  = (pfx_v > suf_v) ? pfx_v : suf_v;
  assign win_in = (XW'(p_idx_q) + XW'(w_q)) <= XW'(SHEET_WIDTH);

  assign fits    = (SUMW'(best_q) + SUMW'(h_q)) <= SUMW'(SHEET_HEIGHT);
  assign bad_req = (w_q == '0) || (h_q == '0) ||
                   (32'(w_q) > 32'(SHEET_WIDTH)) || (32'(h_q) > 32'(SHEET_HEIGHT));

  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    p_vld_d   = iss_q && (state_q == S_UP || state_q == S_DOWN);
    p_idx_d   = cnt_q;
    cnt_d     = cnt_q;
    sheets_d  = sheets_q;
    w_d       = w_q;
    h_d       = h_q;
    blk_d     = blk_q;
    rem_d     = rem_q;
    prefix_d  = prefix_q;
    suf_d     = suf_q;
    best_d    = best_q;
    wval_d    = wval_q;
    pos_d     = pos_q;
    found_d   = found_q;
    res_d     = res_q;
    col_we    = 1'b0;
    col_wdata = wval_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          w_d     = req_width_i;
          h_d     = req_height_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (bad_req) begin
          res_d   = '{status: ST_TOO_LARGE, default: '0};
          state_d = S_RESP;
        end else if (sheets_q == '0) begin
          state_d = S_NEW;
        end else begin
          cnt_d   = '0;
          iss_d   = 1'b1;
          blk_d   = '0;
          state_d = S_UP;
        end
      end
      S_UP: begin
        if (iss_q) begin
          if (cnt_q == LAST) begin
            iss_d = 1'b0;
          end else begin
            cnt_d = cnt_q + IW'(1);
          end
        end
        if (p_vld_q) begin
          prefix_d = pre_v;
          blk_d    = blk_end ? '0 : blk_q + REQ_W'(1);
          if (p_idx_q == LAST) begin
            cnt_d   = LAST;
            iss_d   = 1'b1;
            best_d  = HW'(SHEET_HEIGHT);
            found_d = 1'b0;
            state_d = S_DOWN;
          end
        end
      end
      S_DOWN: begin
        if (iss_q) begin
          if (cnt_q == '0) begin
            iss_d = 1'b0;
          end else begin
            cnt_d = cnt_q - IW'(1);
          end
        end
        if (p_vld_q) begin
          suf_d = suf_v;
          if (win_in && win_v < HW'(SHEET_HEIGHT) && win_v <= best_q) begin
            best_d  = win_v;
            pos_d   = p_idx_q;
            found_d = 1'b1;
          end
          if (p_idx_q == '0) begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (found_q && fits) begin
          res_d = '{status:       ST_PLACED,
                    sheet_number: OUT_W'(SW'(sheets_q - SW'(1))),
                    pos_s:        OUT_W'(pos_q),
                    pos_t:        OUT_W'(best_q)};
          cnt_d   = pos_q;
          rem_d   = w_q;
          wval_d  = HW'(SUMW'(best_q) + SUMW'(h_q));
          state_d = S_WRITE;
        end else begin
          state_d = S_NEW;
        end
      end
      S_NEW: begin
        if (sheets_q == SW'(MAX_SHEETS)) begin
          res_d   = '{status: ST_NO_SHEETS, default: '0};
          state_d = S_RESP;
        end else begin
          sheets_d = sheets_q + SW'(1);
          res_d    = '{status:       ST_NEW_SHEET,
                       sheet_number: OUT_W'(sheets_q),
                       pos_s:        '0,
                       pos_t:        '0};
          cnt_d    = '0;
          state_d  = S_CLEAR;
        end
      end
      S_CLEAR: begin
        col_we    = 1'b1;
        col_wdata = (XW'(cnt_q) < XW'(w_q)) ? HW'(h_q) : '0;
        cnt_d     = cnt_q + IW'(1);
        if (cnt_q == LAST) begin
          state_d = S_RESP;
        end
      end
      S_WRITE: begin
        col_we = 1'b1;
        cnt_d  = cnt_q + IW'(1);
        rem_d  = rem_q - REQ_W'(1);
        if (rem_q == REQ_W'(1)) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      iss_q    <= 1'b0;
      p_vld_q  <= 1'b0;
      sheets_q <= '0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      p_vld_q  <= p_vld_d;
      sheets_q <= sheets_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q  <= p_idx_d;
    cnt_q    <= cnt_d;
    w_q      <= w_d;
    h_q      <= h_d;
    blk_q    <= blk_d;
    rem_q    <= rem_d;
    prefix_q <= prefix_d;
    suf_q    <= suf_d;
    best_q   <= best_d;
    wval_q   <= wval_d;
    pos_q    <= pos_d;
    found_q  <= found_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

`ifndef SYNTH
  a_sheets_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sheets_q != $past(sheets_q)) |-> (sheets_q == $past(sheets_q) + SW'(1)))
    else $error("sheet count moved by more than one");

  a_write_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (rem_q != '0))
    else $error("window write-back ran past its width");

  a_best_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && found_q) |-> (best_q < HW'(SHEET_HEIGHT)))
    else $error("chosen window has no room");

  a_placed_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && res_q.status == ST_PLACED) |-> (sheets_q != '0))
    else $error("placement reported without an open sheet");
`endif

endmodule

// File: rtl/core/skyline_atlas_allocator.sv
// channel  dir  tdata (low bit up)                     tuser     tlast
// s_axis   in   req_width[8:0] req_height[17:9]         -         -
// m_axis   out  sheet_number[7:0] pos_s[15:8] pos_t[23:16]  status[1:0]  -
//
// one item at a time; a rejected request goes from S_CHECK straight to S_RESP
// placement in the open sheet: prefix pass and suffix pass over the column
// memory, one column a cycle, then write-back of w columns
// a new sheet adds a fill of all SHEET_WIDTH columns; the first item after reset
// skips both passes and goes straight to a new sheet
// reset needs no memory sweep; the next item is taken while a result waits

module skyline_atlas_allocator
  import sklat_pkg::*;
#(
  parameter int unsigned SHEET_WIDTH  = 256,
  parameter int unsigned SHEET_HEIGHT = 256,
  parameter int unsigned MAX_SHEETS   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // req_width, req_height
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // sheet_number, pos_s, pos_t
  output logic [1:0]  m_axis_tuser    // status
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic m_vld_q, m_vld_d;
  res_t m_res_q, m_res_d;

  sklat_engine #(
    .SHEET_WIDTH  (SHEET_WIDTH),
    .SHEET_HEIGHT (SHEET_HEIGHT),
    .MAX_SHEETS   (MAX_SHEETS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_width_i  (s_axis_tdata[8:0]),
    .req_height_i (s_axis_tdata[17:9]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register
  assign res_ready = !m_vld_q || m_axis_tready;

  always_comb begin
    m_vld_d = m_vld_q;
    m_res_d = m_res_q;
    if (res_ready) begin
      m_vld_d = res_valid;
      if (res_valid) begin
        m_res_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tuser  = m_res_q.status;
  assign m_axis_tdata  = {m_res_q.pos_t, m_res_q.pos_s, m_res_q.sheet_number};

endmodule

// File: verif/skyline_atlas_allocator_test.sv
module skyline_atlas_allocator_test;
  import sklat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int SHEET_W      = 256;
  localparam int SHEET_H      = 256;
  localparam int MAX_SH       = 256;
  localparam int N_DIR        = 24;
  localparam int N_RAND       = 1226;
  localparam int EAT_FROM     = 850;
  localparam int PAUSE_AT     = 500;
  localparam int LONG_HOLD_AT = 150;
  localparam int LONG_HOLD    = 4000;
  localparam int DRAIN_CYCLES = 1100;

  typedef struct packed {
    logic [8:0] w;
    logic [8:0] h;
    logic       typed;
    res_t       want;
  } alloc_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // req_width[8:0], req_height[17:9]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // sheet_number[7:0], pos_s[15:8], pos_t[23:16]
  logic [1:0]  m_axis_tuser;        // status[1:0]

  logic [8:0] skyline [SHEET_W];
  logic [8:0] sheets_open;
  res_t       placement_q [$];
  int         n_sent;
  int         results_seen;
  int         n_fail;
  int         idle_phase;
  int         status_count [4];

  // expected values typed in only where obvious
  alloc_row_t dir_table [N_DIR] = '{
    '{9'd1,   9'd1,   1'b1, '{ST_NEW_SHEET, 8'd0, 8'd0, 8'd0}},
    '{9'd0,   9'd5,   1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0, 8'd0}},
    '{9'd5,   9'd0,   1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0, 8'd0}},
    '{9'd257, 9'd1,   1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0, 8'd0}},
    '{9'd1,   9'd257, 1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0, 8'd0}},
    '{9'd511, 9'd511, 1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0, 8'd0}},
    '{9'd0,   9'd0,   1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0, 8'd0}},
    '{9'd256, 9'd1,   1'b0, '0},
    '{9'd256, 9'd254, 1'b0, '0},
    '{9'd1,   9'd1,   1'b0, '0},
    '{9'd256, 9'd256, 1'b0, '0},
    '{9'd128, 9'd10,  1'b0, '0},
    '{9'd128, 9'd20,  1'b0, '0},
    '{9'd64,  9'd5,   1'b0, '0},
    '{9'd64,  9'd5,   1'b0, '0},
    '{9'd255, 9'd200, 1'b0, '0},
    '{9'd1,   9'd256, 1'b0, '0},
    '{9'd256, 9'd1,   1'b0, '0},
    '{9'd256, 9'd256, 1'b0, '0},
    '{9'd170, 9'd85,  1'b0, '0},
    '{9'd85,  9'd170, 1'b0, '0},
    '{9'd255, 9'd255, 1'b0, '0},
    '{9'd16,  9'd511, 1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0, 8'd0}},
    '{9'd258, 9'd256, 1'b1, '{ST_TOO_LARGE, 8'd0, 8'd0, 8'd0}}
  };

  skyline_atlas_allocator #(
    .SHEET_WIDTH (SHEET_W),
    .SHEET_HEIGHT(SHEET_H),
    .MAX_SHEETS  (MAX_SH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // lowest window wins, leftmost among equals; raises the window on success
  function automatic bit fit_skyline(input logic [8:0] w, input logic [8:0] h,
                                     output logic [8:0] corner_s,
                                     output logic [8:0] corner_t);
    int  best;
    int  pos;
    int  top;
    bit  found;
    bit  ok;
    best = SHEET_H;
    pos = 0;
    found = 1'b0;
    corner_s = '0;
    corner_t = '0;
    for (int s = 0; s + w <= SHEET_W; s++) begin
      top = 0;
      ok = 1'b1;
      for (int k = 0; k < w; k++) begin
        if (skyline[s + k] >= best) begin
          ok = 1'b0;
          break;
        end
        if (skyline[s + k] > top) top = skyline[s + k];
      end
      if (ok) begin
        pos = s;
        best = top;
        found = 1'b1;
      end
    end
    if (!found || best + h > SHEET_H) return 1'b0;
    for (int k = 0; k < w; k++) skyline[pos + k] = 9'(best + h);
    corner_s = 9'(pos);
    corner_t = 9'(best);
    return 1'b1;
  endfunction

  function automatic res_t allocate_rect(input logic [8:0] w, input logic [8:0] h);
    res_t       r;
    logic [8:0] cs;
    logic [8:0] ct;
    r = '0;
    if (w == 0 || h == 0 || w > SHEET_W || h > SHEET_H) begin
      r.status = ST_TOO_LARGE;
    end else if (fit_skyline(w, h, cs, ct)) begin
      r.status = ST_PLACED;
      r.sheet_number = 8'(sheets_open - 9'd1);
      r.pos_s = cs[7:0];
      r.pos_t = ct[7:0];
    end else if (sheets_open >= MAX_SH) begin
      r.status = ST_NO_SHEETS;
    end else begin
      sheets_open = sheets_open + 9'd1;
      for (int i = 0; i < SHEET_W; i++) skyline[i] = '0;
      void'(fit_skyline(w, h, cs, ct));
      r.status = ST_NEW_SHEET;
      r.sheet_number = 8'(sheets_open - 9'd1);
      r.pos_s = cs[7:0];
      r.pos_t = ct[7:0];
    end
    return r;
  endfunction

  task automatic send_request(input logic [8:0] w, input logic [8:0] h,
                              input logic typed, input res_t want);
    int   pct;
    res_t predicted;
    pct = (idle_phase == 0) ? 33 : (idle_phase == 1) ? 68 : 0;
    while ($urandom_range(99) < pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, h, w};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = allocate_rect(w, h);
    placement_q.push_back(typed ? want : predicted);
    n_sent++;
    idle_phase = (n_sent < 420) ? 0 : (n_sent < 840) ? 1 : 2;
  endtask

  task automatic pick_request(input bit eat_sheets,
                              output logic [8:0] w, output logic [8:0] h);
    int dice;
    dice = $urandom_range(99);
    if (dice < 4) begin
      w = 9'($urandom_range(511, SHEET_W + 1));
      h = 9'($urandom_range(511, 0));
    end else if (dice < 8) begin
      w = 9'($urandom_range(511, 0));
      h = 9'($urandom_range(511, SHEET_H + 1));
    end else if (dice < 10) begin
      w = 9'($urandom_range(3, 0));
      h = (w == 0) ? 9'($urandom_range(511, 0)) : 9'd0;
    end else if (eat_sheets && dice < 75) begin
      // too big to share a sheet in either direction
      w = 9'($urandom_range(SHEET_W, SHEET_W / 2 + 1));
      h = 9'($urandom_range(SHEET_H, SHEET_H / 2 + 1));
    end else if (eat_sheets || dice < 50) begin
      w = 9'($urandom_range(32, 1));
      h = 9'($urandom_range(32, 1));
    end else if (dice < 82) begin
      w = 9'($urandom_range(128, 1));
      h = 9'($urandom_range(128, 1));
    end else begin
      w = 9'($urandom_range(SHEET_W, 64));
      h = 9'($urandom_range(SHEET_H, 64));
    end
  endtask

  // request side
  initial begin
    logic [8:0] w;
    logic [8:0] h;
    n_sent = 0;
    results_seen = 0;
    n_fail = 0;
    idle_phase = 0;
    sheets_open = '0;
    for (int i = 0; i < 4; i++) status_count[i] = 0;
    for (int i = 0; i < SHEET_W; i++) skyline[i] = 9'(SHEET_H);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_request(dir_table[i].w, dir_table[i].h, dir_table[i].typed, dir_table[i].want);
    end

    for (int i = 0; i < N_RAND; i++) begin
      if (i == PAUSE_AT) begin
        s_axis_tvalid <= 1'b0;
        while (placement_q.size() != 0) @(posedge clk_i);
      end
      pick_request(i >= EAT_FROM, w, h);
      send_request(w, h, 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests: %0d placed, %0d on a new sheet, %0d rejected, %0d out of sheets",
             n_sent, status_count[ST_PLACED], status_count[ST_NEW_SHEET],
             status_count[ST_TOO_LARGE], status_count[ST_NO_SHEETS]);
    $display("sheets opened: %0d of %0d", sheets_open, MAX_SH);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side
  initial begin
    res_t want;
    int   hold_left;
    bit   hold_done;
    int   pct;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (placement_q.size() == 0) begin
          $error("unexpected item: status %0d tdata %h", m_axis_tuser, m_axis_tdata);
          n_fail++;
        end else begin
          want = placement_q.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            n_fail++;
          end
          if (m_axis_tdata[7:0] !== want.sheet_number) begin
            $error("sheet_number: expected %0d, got %0d", want.sheet_number,
                   m_axis_tdata[7:0]);
            n_fail++;
          end
          if (m_axis_tdata[15:8] !== want.pos_s) begin
            $error("pos_s: expected %0d, got %0d", want.pos_s, m_axis_tdata[15:8]);
            n_fail++;
          end
          if (m_axis_tdata[23:16] !== want.pos_t) begin
            $error("pos_t: expected %0d, got %0d", want.pos_t, m_axis_tdata[23:16]);
            n_fail++;
          end
          status_count[want.status]++;
          results_seen++;
        end
      end
      if (!hold_done && results_seen >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      pct = (idle_phase == 0) ? 68 : (idle_phase == 1) ? 33 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= pct);
      end
    end
  end

  initial begin
    #100ms;
    $display("timeout after %0d requests, %0d results", n_sent, results_seen);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
